FILE: hdl/lt_pkg.sv
// Shared types, constants and index tables for the two-view triangulation block.
`default_nettype none
package lt_pkg;

  localparam int SysW = 33;   // system entry, exact at scale 2^16
  localparam int NrmW = 68;   // normal matrix and right side entries
  localparam int CofW = 136;  // 2x2 cofactors
  localparam int AccW = 206;  // 3x3 determinants
  localparam int MagW = 68;   // multiplier magnitude, bit-serial
  localparam int RemW = 240;  // divider remainder and shifted divisor
  localparam int QuoW = 33;   // quotient with overflow bit on top

  localparam logic [2:0] REG_CAM1_ROW0 = 3'd0;
  localparam logic [2:0] REG_CAM1_ROW1 = 3'd1;
  localparam logic [2:0] REG_CAM1_ROW2 = 3'd2;
  localparam logic [2:0] REG_CAM2_ROW0 = 3'd3;
  localparam logic [2:0] REG_CAM2_ROW1 = 3'd4;
  localparam logic [2:0] REG_CAM2_ROW2 = 3'd5;

  localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [63:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [63:0] ROW2_RST = 64'h0000_1000_0000_0000;

  typedef struct packed {
    logic [15:0] first_x;
    logic [15:0] first_y;
    logic [15:0] second_x;
    logic [15:0] second_y;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               degenerate;
  } point_t;

  typedef logic signed [SysW-1:0] sys_t;

  typedef struct packed {
    sys_t [2:0] a;
    sys_t       h;
  } sys_row_t;

  typedef struct packed {
    sys_row_t [3:0] rows;
  } sys_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPA,
    ST_OPB,
    ST_RUN,
    ST_STORE,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_SAT,
    ST_RESULT
  } state_t;

  function automatic logic signed [15:0] cam_entry(input logic [63:0] row,
                                                   input logic [1:0] k);
    return row[16*k +: 16];
  endfunction

  function automatic logic signed [AccW-1:0] ext_sys(input logic signed [SysW-1:0] v);
    return AccW'(v);
  endfunction

  function automatic logic signed [AccW-1:0] ext_nrm(input logic signed [NrmW-1:0] v);
    return AccW'(v);
  endfunction

  function automatic logic signed [AccW-1:0] ext_cof(input logic signed [CofW-1:0] v);
    return AccW'(v);
  endfunction

  // first factor of cofactor products
  function automatic logic [3:0] a_idx(input logic [3:0] op);
    case (op)
      4'd0: return 4'd4;
      4'd1: return 4'd5;
      4'd2: return 4'd3;
      4'd3: return 4'd5;
      4'd4: return 4'd3;
      4'd5: return 4'd4;
      default: return 4'd0;
    endcase
  endfunction

  // second factor of cofactor products
  function automatic logic [3:0] b_idx(input logic [3:0] op);
    case (op)
      4'd0: return 4'd8;
      4'd1: return 4'd7;
      4'd2: return 4'd8;
      4'd3: return 4'd6;
      4'd4: return 4'd7;
      4'd5: return 4'd6;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [1:0] idx_row(input logic [3:0] idx);
    case (idx)
      4'd0, 4'd1, 4'd2: return 2'd0;
      4'd3, 4'd4, 4'd5: return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] idx_col(input logic [3:0] idx);
    case (idx)
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  // normal phase targets: six unique matrix entries, then three right side entries
  function automatic logic [1:0] tgt_col_a(input logic [3:0] tgt);
    case (tgt)
      4'd0, 4'd1, 4'd2, 4'd6: return 2'd0;
      4'd3, 4'd4, 4'd7:       return 2'd1;
      default:                return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] tgt_col_b(input logic [3:0] tgt);
    case (tgt)
      4'd0:       return 2'd0;
      4'd1, 4'd3: return 2'd1;
      default:    return 2'd2;
    endcase
  endfunction

  function automatic logic [3:0] tgt_ia(input logic [3:0] tgt);
    case (tgt)
      4'd0: return 4'd0;
      4'd1: return 4'd1;
      4'd2: return 4'd2;
      4'd3: return 4'd4;
      4'd4: return 4'd5;
      default: return 4'd8;
    endcase
  endfunction

  function automatic logic [3:0] tgt_ib(input logic [3:0] tgt);
    case (tgt)
      4'd0: return 4'd0;
      4'd1: return 4'd3;
      4'd2: return 4'd6;
      4'd3: return 4'd4;
      4'd4: return 4'd7;
      default: return 4'd8;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lt_front.sv
// Front end: camera registers, input stage and construction of the 4x3 system.
`default_nettype none
module lt_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pair_valid,
  output logic                   pair_ready,
  input  wire lt_pkg::pair_t     pair_word,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [63:0]       cfg_data,
  output logic                   push,
  output lt_pkg::sys_item_t      push_item,
  input  wire logic              space
);
  import lt_pkg::*;

  logic [63:0] cam1_row0, cam1_row1, cam1_row2;
  logic [63:0] cam2_row0, cam2_row1, cam2_row2;
  logic        st_valid;
  sys_item_t   st_item;
  sys_item_t   sys_next;

  function automatic sys_row_t make_row(input logic [15:0] crd, input logic [63:0] top,
                                        input logic [63:0] bot);
    sys_row_t t;
    sys_t     cv, eb, et;
    cv = SysW'({1'b0, crd});
    for (int k = 0; k < 3; k++) begin
      eb = SysW'(cam_entry(bot, 2'(k)));
      et = SysW'(cam_entry(top, 2'(k)));
      t.a[k] = cv * eb - (et <<< 4);
    end
    eb = SysW'(cam_entry(bot, 2'd3));
    et = SysW'(cam_entry(top, 2'd3));
    t.h = (et <<< 4) - cv * eb;
    return t;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam1_row0 <= ROW0_RST;
      cam1_row1 <= ROW1_RST;
      cam1_row2 <= ROW2_RST;
      cam2_row0 <= ROW0_RST;
      cam2_row1 <= ROW1_RST;
      cam2_row2 <= ROW2_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAM1_ROW0: cam1_row0 <= cfg_data;
        REG_CAM1_ROW1: cam1_row1 <= cfg_data;
        REG_CAM1_ROW2: cam1_row2 <= cfg_data;
        REG_CAM2_ROW0: cam2_row0 <= cfg_data;
        REG_CAM2_ROW1: cam2_row1 <= cfg_data;
        REG_CAM2_ROW2: cam2_row2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sys_next.rows[0] = make_row(pair_word.first_x,  cam1_row0, cam1_row2);
    sys_next.rows[1] = make_row(pair_word.first_y,  cam1_row1, cam1_row2);
    sys_next.rows[2] = make_row(pair_word.second_x, cam2_row0, cam2_row2);
    sys_next.rows[3] = make_row(pair_word.second_y, cam2_row1, cam2_row2);
  end

  assign pair_ready = !st_valid || space;
  assign push       = st_valid && space;
  assign push_item  = st_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (pair_ready) begin
      st_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_valid && pair_ready) begin
      st_item <= sys_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lt_queue.sv
// Two-entry queue of built systems between the front end and the solver.
`default_nettype none
module lt_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lt_pkg::sys_item_t push_item,
  output logic                   space,
  input  wire logic              pop,
  output lt_pkg::sys_item_t      pop_item,
  output logic                   avail
);
  import lt_pkg::*;

  sys_item_t  slot [2];
  logic [1:0] count;
  logic       wr, rd;

  assign space    = (count != 2'd2);
  assign avail    = (count != 2'd0);
  assign pop_item = slot[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wr    <= 1'b0;
      rd    <= 1'b0;
    end else begin
      if (push) wr <= !wr;
      if (pop)  rd <= !rd;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lt_solver.sv
// Solver: normal equations and Cramer determinants on one serial MAC, plus a rounding divider.
`default_nettype none
module lt_solver (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire lt_pkg::sys_item_t q_data,
  output logic                   q_pop,
  output logic                   point_valid,
  input  wire logic              point_ready,
  output lt_pkg::point_t         point_word
);
  import lt_pkg::*;

  state_t state, state_next;

  sys_item_t item;
  logic      nphase;
  logic [3:0] tgt, op;
  logic [1:0] row, dj;

  logic signed [NrmW-1:0] nrm [9];
  logic signed [NrmW-1:0] nv  [3];
  logic signed [CofW-1:0] cof [3];

  logic signed [AccW-1:0] acc, ashift, opnd, acc_mag;
  logic [MagW-1:0]        bmag;
  logic                   bneg;
  logic [AccW-1:0]        den_mag;
  logic                   den_neg;
  logic [RemW-1:0]        rem, dsh;
  logic [QuoW-1:0]        quo;
  logic [5:0]             cnt;
  logic                   qneg;
  logic signed [31:0]     res_x, res_y, res_z, sat;
  logic                   degen;

  logic       clr, sub, acc_zero, load_out;
  logic [3:0] eidx;
  logic [1:0] erow, ecol, bcol;

  assign clr      = nphase ? (row == 2'd0)
                           : (op == 4'd0 || op == 4'd2 || op == 4'd4 || op == 4'd6);
  assign sub      = !nphase && op[0];
  assign acc_zero = (acc == '0);
  assign acc_mag  = acc[AccW-1] ? -acc : acc;

  // operand fetch: one selection shared by both factors of a product
  always_comb begin
    if (state == ST_OPA) begin
      eidx = a_idx(op);
    end else if (op >= 4'd6) begin
      eidx = op - 4'd6;
    end else begin
      eidx = b_idx(op);
    end
    erow = idx_row(eidx);
    ecol = idx_col(eidx);
    bcol = tgt_col_b(tgt);
    if (nphase) begin
      if (state == ST_OPA) begin
        opnd = ext_sys(item.rows[row].a[tgt_col_a(tgt)]);
      end else if (tgt < 4'd6) begin
        opnd = ext_sys(item.rows[row].a[bcol]);
      end else begin
        opnd = ext_sys(item.rows[row].h);
      end
    end else if (state == ST_OPA && op >= 4'd6) begin
      opnd = ext_cof(cof[2'(op - 4'd6)]);
    end else if (dj != 2'd0 && ecol == dj - 2'd1) begin
      opnd = ext_nrm(nv[erow]);
    end else begin
      opnd = ext_nrm(nrm[eidx]);
    end
  end

  always_comb begin
    if (quo[QuoW-1] || (!qneg && quo[31:0] > 32'h7FFF_FFFF)) begin
      sat = qneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (qneg && quo[31:0] > 32'h8000_0000) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = qneg ? 32'(32'd0 - quo[31:0]) : quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_OPA;
        end
      end
      ST_OPA: state_next = ST_OPB;
      ST_OPB: state_next = ST_RUN;
      ST_RUN: begin
        if (bmag == '0) state_next = ST_STORE;
      end
      ST_STORE: begin
        if (nphase || op != 4'd8) begin
          state_next = ST_OPA;
        end else if (dj == 2'd0) begin
          state_next = acc_zero ? ST_RESULT : ST_OPA;
        end else begin
          state_next = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (cnt == 6'd0) state_next = ST_SAT;
      end
      ST_SAT: state_next = (dj == 2'd3) ? ST_RESULT : ST_OPA;
      ST_RESULT: begin
        if (!point_valid || point_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          item   <= q_data;
          nphase <= 1'b1;
          tgt    <= 4'd0;
          row    <= 2'd0;
          degen  <= 1'b0;
        end
      end
      ST_OPA: begin
        ashift <= opnd;
        if (clr) acc <= '0;
      end
      ST_OPB: begin
        bmag <= MagW'(opnd[AccW-1] ? -opnd : opnd);
        bneg <= opnd[AccW-1] ^ sub;
      end
      ST_RUN: begin
        if (bmag != '0) begin
          if (bmag[0]) acc <= bneg ? acc - ashift : acc + ashift;
          ashift <= ashift <<< 1;
          bmag   <= bmag >> 1;
        end
      end
      ST_STORE: begin
        if (nphase) begin
          if (row == 2'd3) begin
            if (tgt < 4'd6) begin
              nrm[tgt_ia(tgt)] <= acc[NrmW-1:0];
              nrm[tgt_ib(tgt)] <= acc[NrmW-1:0];
            end else begin
              nv[2'(tgt - 4'd6)] <= acc[NrmW-1:0];
            end
            if (tgt == 4'd8) begin
              nphase <= 1'b0;
              dj     <= 2'd0;
              op     <= 4'd0;
            end else begin
              tgt <= tgt + 4'd1;
            end
            row <= 2'd0;
          end else begin
            row <= row + 2'd1;
          end
        end else begin
          if (op == 4'd1 || op == 4'd3 || op == 4'd5) begin
            cof[2'(op >> 1)] <= acc[CofW-1:0];
          end
          if (op == 4'd8) begin
            if (dj == 2'd0) begin
              den_mag <= acc_mag;
              den_neg <= acc[AccW-1];
              dj      <= 2'd1;
              op      <= 4'd0;
              if (acc_zero) degen <= 1'b1;
            end
          end else begin
            op <= op + 4'd1;
          end
        end
      end
      ST_DIV_INIT: begin
        // round half away: (2|num|*2^16 + |den|) / (2|den|)
        rem  <= (RemW'(acc_mag) << 17) + RemW'(den_mag);
        dsh  <= RemW'(den_mag) << 33;
        quo  <= '0;
        cnt  <= 6'd32;
        qneg <= acc[AccW-1] ^ den_neg;
      end
      ST_DIV_RUN: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[QuoW-2:0], 1'b1};
        end else begin
          quo <= {quo[QuoW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 6'd1;
      end
      ST_SAT: begin
        case (dj)
          2'd1:    res_x <= sat;
          2'd2:    res_y <= sat;
          default: res_z <= sat;
        endcase
        dj <= dj + 2'd1;
        op <= 4'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (load_out) begin
      point_valid <= 1'b1;
    end else if (point_ready) begin
      point_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      point_word.point_x    <= degen ? '0 : res_x;
      point_word.point_y    <= degen ? '0 : res_y;
      point_word.point_z    <= degen ? '0 : res_z;
      point_word.degenerate <= degen;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/linear_triangulation.sv
// Top level of the two-view linear least-squares triangulation block.
//
//   port group    dir  payload                        handshake
//   pair_*        in   pair_t (two image points)      pair_valid / pair_ready
//   point_*       out  point_t (Q16.16 point, flag)   point_valid / point_ready
//   cfg_*         in   register index, 64-bit data    cfg_valid / cfg_ready
//
// The front end builds the system combinationally, registers it in its input stage
// and parks it in a two-word queue. The solver runs every product on one bit-serial
// multiply-accumulate unit and a one-bit-per-cycle divider: 36 products for the
// normal equations and 36 for the four determinants, each with one shift-add step per
// significant bit of the second factor, then one rounding division per coordinate.
// Reset is synchronous; it loads identity cameras and empties the queue.
// A stalled result holds in the output register while the solver takes the next word.
`default_nettype none
module linear_triangulation (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pair_valid,
  output logic                pair_ready,
  input  wire lt_pkg::pair_t  pair_word,
  output logic                point_valid,
  input  wire logic           point_ready,
  output lt_pkg::point_t      point_word,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [63:0]    cfg_data
);
  import lt_pkg::*;

  logic      q_push, q_space, q_pop, q_avail;
  sys_item_t q_in, q_out;

  lt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .pair_word  (pair_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (q_push),
    .push_item  (q_in),
    .space      (q_space)
  );

  lt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .space     (q_space),
    .pop       (q_pop),
    .pop_item  (q_out),
    .avail     (q_avail)
  );

  lt_solver u_solver (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_avail),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .point_word  (point_word)
  );

  a_pop_has_word: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_avail)
    else $error("solver took a word from an empty queue");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_word.degenerate |->
      point_word.point_x == 0 && point_word.point_y == 0 && point_word.point_z == 0)
    else $error("degenerate result carries a nonzero point");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_pop |=> q_avail)
    else $error("queue lost a pushed word");

endmodule
`default_nettype wire

FILE: tb/tb_linear_triangulation.sv
// Self-checking testbench for the two-view triangulation block.
`default_nettype none
module tb_linear_triangulation;
  import lt_pkg::*;

  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;
  localparam int WORD_LATENCY = 4100;
  localparam int HOLD_CYCLES = 15000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 150;

  typedef logic signed [255:0] wint_t;
  typedef wint_t mat3_t [9];

  typedef enum logic [2:0] {
    CAM_RESET, CAM_ZERO, CAM_MAX, CAM_MIN, CAM_RAND, CAM_NEAR
  } cam_set_e;

  typedef struct {
    cam_set_e cams;
    pair_t    pair;
    bit       typed;
    point_t   want;
  } dir_row_t;

  localparam point_t ZERO_PT = '{point_x: 0, point_y: 0, point_z: 0, degenerate: 1'b0};
  localparam point_t DEGEN_PT = '{point_x: 0, point_y: 0, point_z: 0, degenerate: 1'b1};

  dir_row_t dir_rows [] = '{
    '{CAM_RESET, {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, DEGEN_PT},
    '{CAM_RESET, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, DEGEN_PT},
    '{CAM_RESET, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b1, DEGEN_PT},
    '{CAM_RESET, {16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1, ZERO_PT},
    '{CAM_RESET, {16'h0140, 16'h00F0, 16'h0150, 16'h00E0}, 1'b0, ZERO_PT},
    '{CAM_ZERO,  {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, DEGEN_PT},
    '{CAM_ZERO,  {16'hFFFF, 16'h1234, 16'h8000, 16'h7FFF}, 1'b1, DEGEN_PT},
    '{CAM_MAX,   {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, ZERO_PT},
    '{CAM_MAX,   {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, ZERO_PT},
    '{CAM_MAX,   {16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF}, 1'b0, ZERO_PT},
    '{CAM_MIN,   {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, ZERO_PT},
    '{CAM_MIN,   {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, ZERO_PT},
    '{CAM_NEAR,  {16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b0, ZERO_PT},
    '{CAM_NEAR,  {16'h1400, 16'h0F00, 16'h1380, 16'h0F20}, 1'b0, ZERO_PT}
  };

  logic        clk;
  logic        rst;
  logic        pair_valid;
  logic        pair_ready;
  pair_t       pair_word;
  logic        point_valid;
  logic        point_ready;
  point_t      point_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  logic [63:0] cam_rows [6];
  point_t      pending_points [$];
  int          mismatches;
  int          burst_left;
  bit          hold_req;
  cam_set_e    cam_now;

  linear_triangulation dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready), .pair_word(pair_word),
    .point_valid(point_valid), .point_ready(point_ready), .point_word(point_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #600_000_000;
    $display("Mismatches found");
    $finish;
  end

  // signed Q4.12 entry k of a packed camera row
  function automatic wint_t cam_q(input logic [63:0] row, input int k);
    logic signed [15:0] raw;
    raw = row[16*k +: 16];
    return wint_t'(raw);
  endfunction

  function automatic wint_t det_3x3(input mat3_t m);
    return m[0] * (m[4] * m[8] - m[5] * m[7])
         - m[1] * (m[3] * m[8] - m[5] * m[6])
         + m[2] * (m[3] * m[7] - m[4] * m[6]);
  endfunction

  // round(num * 2^16 / den), ties away from zero, saturated to 32 bits
  function automatic logic [31:0] q16_ratio(input wint_t num, input wint_t den);
    bit    neg;
    wint_t an, ad, q;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (an * 131072 + ad) / (ad + ad);
    if (!neg) return (q > 'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    return (q > 'h8000_0000) ? 32'h8000_0000 : 32'(-q);
  endfunction

  function automatic point_t triangulate(input pair_t p);
    wint_t  sys [4][3];
    wint_t  rhs [4];
    wint_t  crd [4];
    mat3_t  nrm, cram;
    wint_t  nrv [3];
    wint_t  den;
    logic [31:0] coord [3];
    logic [63:0] top, bot;
    point_t res;
    crd[0] = wint_t'(p.first_x);
    crd[1] = wint_t'(p.first_y);
    crd[2] = wint_t'(p.second_x);
    crd[3] = wint_t'(p.second_y);
    for (int r = 0; r < 4; r++) begin
      top = cam_rows[(r / 2) * 3 + (r % 2)];
      bot = cam_rows[(r / 2) * 3 + 2];
      for (int c = 0; c < 3; c++) sys[r][c] = crd[r] * cam_q(bot, c) - cam_q(top, c) * 16;
      rhs[r] = cam_q(top, 3) * 16 - crd[r] * cam_q(bot, 3);
    end
    for (int c = 0; c < 3; c++) begin
      nrv[c] = 0;
      for (int r = 0; r < 4; r++) nrv[c] += sys[r][c] * rhs[r];
      for (int k = 0; k < 3; k++) begin
        nrm[c * 3 + k] = 0;
        for (int r = 0; r < 4; r++) nrm[c * 3 + k] += sys[r][c] * sys[r][k];
      end
    end
    den = det_3x3(nrm);
    if (den == 0) return DEGEN_PT;
    for (int k = 0; k < 3; k++) begin
      cram = nrm;
      for (int r = 0; r < 3; r++) cram[r * 3 + k] = nrv[r];
      coord[k] = q16_ratio(det_3x3(cram), den);
    end
    res.point_x = coord[0];
    res.point_y = coord[1];
    res.point_z = coord[2];
    res.degenerate = 1'b0;
    return res;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("[%0t] %s: got %0d, want %0d", $time, field, got, want);
    mismatches++;
  endtask

  // check every returned word against the oldest pending prediction
  always @(posedge clk) begin
    if (!rst && point_valid && point_ready) begin
      if (pending_points.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        point_t want;
        want = pending_points.pop_front();
        if (point_word.point_x !== want.point_x) report("point_x", point_word.point_x, want.point_x);
        if (point_word.point_y !== want.point_y) report("point_y", point_word.point_y, want.point_y);
        if (point_word.point_z !== want.point_z) report("point_z", point_word.point_z, want.point_z);
        if (point_word.degenerate !== want.degenerate)
          report("degenerate", point_word.degenerate, want.degenerate);
      end
    end
  end

  // receiver: random stall pattern, one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    point_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        point_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 3000);
        end
        mode_left--;
        case (mode)
          0: point_ready <= 1'b1;
          1: point_ready <= ($urandom_range(0, 3) != 0);
          default: point_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // append a prediction at the tail of the pending list
  task automatic add_pending(input point_t p);
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic send_pair(input pair_t p);
    if (burst_left == 0) burst_left = ($urandom_range(0, 7) == 0) ? 50 : $urandom_range(1, 12);
    pair_word <= p;
    pair_valid <= 1'b1;
    do @(posedge clk); while (!pair_ready);
    add_pending(triangulate(p));
    burst_left--;
    if (burst_left == 0) begin
      pair_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain;
    if (pair_valid) begin
      pair_valid <= 1'b0;
      @(posedge clk);
    end
    burst_left = 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [63:0] near_row(input int diag);
    logic [63:0] row;
    for (int k = 0; k < 3; k++)
      row[16*k +: 16] = 16'((k == diag ? 4096 : 0) + $signed($urandom_range(0, 1024)) - 512);
    row[63:48] = 16'($urandom_range(0, 16'hFFFF));
    return row;
  endfunction

  task automatic load_cams(input cam_set_e kind);
    logic [63:0] rows [6];
    drain();
    for (int i = 0; i < 6; i++) begin
      case (kind)
        CAM_RESET: rows[i] = (i % 3 == 0) ? ROW0_RST : (i % 3 == 1) ? ROW1_RST : ROW2_RST;
        CAM_ZERO:  rows[i] = '0;
        CAM_MAX:   rows[i] = {4{16'h7FFF}};
        CAM_MIN:   rows[i] = {4{16'h8000}};
        CAM_RAND:  rows[i] = {$urandom, $urandom};
        default:   rows[i] = near_row(i % 3);
      endcase
    end
    cfg_valid <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      case (i)
        0: cfg_index <= REG_CAM1_ROW0;
        1: cfg_index <= REG_CAM1_ROW1;
        2: cfg_index <= REG_CAM1_ROW2;
        3: cfg_index <= REG_CAM2_ROW0;
        4: cfg_index <= REG_CAM2_ROW1;
        5: cfg_index <= REG_CAM2_ROW2;
        6: cfg_index <= REG_SPARE6;
        default: cfg_index <= REG_SPARE7;
      endcase
      // writes to the spare indexes must leave the cameras alone
      cfg_data <= (i < 6) ? rows[i] : {$urandom, $urandom};
      do @(posedge clk); while (!cfg_ready);
      if (i < 6) cam_rows[i] = rows[i];
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    cam_now = kind;
  endtask

  function automatic pair_t rand_pair(input bit wide);
    pair_t p;
    if (wide) return {$urandom, $urandom};
    p.first_x = 16'($urandom_range(0, 640 * 16));
    p.first_y = 16'($urandom_range(0, 480 * 16));
    p.second_x = 16'($urandom_range(0, 640 * 16));
    p.second_y = 16'($urandom_range(0, 480 * 16));
    return p;
  endfunction

  initial begin
    cam_set_e phase_kinds [RAND_PHASES];
    rst = 1'b1;
    pair_valid = 1'b0;
    pair_word = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CAM1_ROW0;
    cfg_data = '0;
    mismatches = 0;
    burst_left = 0;
    hold_req = 1'b0;
    cam_now = CAM_RESET;
    cam_rows[0] = ROW0_RST; cam_rows[1] = ROW1_RST; cam_rows[2] = ROW2_RST;
    cam_rows[3] = ROW0_RST; cam_rows[4] = ROW1_RST; cam_rows[5] = ROW2_RST;
    phase_kinds = '{CAM_NEAR, CAM_RAND, CAM_MAX, CAM_NEAR, CAM_MIN,
                    CAM_RAND, CAM_ZERO, CAM_NEAR, CAM_RESET, CAM_RAND};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cams != cam_now) load_cams(dir_rows[i].cams);
      if (dir_rows[i].typed) begin
        point_t pred;
        // the typed value must agree with the predictor before it stands in
        send_pair(dir_rows[i].pair);
        pred = pending_points.pop_back();
        if (pred !== dir_rows[i].want) report("typed row", i, 0);
        add_pending(dir_rows[i].want);
      end else begin
        send_pair(dir_rows[i].pair);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_cams(phase_kinds[ph]);
      // receiver holds off while the first phase goes in, so the input backs up
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_pair(rand_pair($urandom_range(0, 2) == 0));
    end

    drain();
    repeat (WORD_LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/lt_pkg.sv
hdl/lt_front.sv
hdl/lt_queue.sv
hdl/lt_solver.sv
hdl/linear_triangulation.sv
tb/tb_linear_triangulation.sv
